// ----- src/duet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duet_pkg
// Shared types and constants of the duet instruction executor.
// ----------------------------------------------------------------------------
package duet_pkg;

    localparam int DATA_W    = 64;
    localparam int FIELD_W   = 32;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = 6;

    typedef enum logic [2:0] {
        OP_SND = 3'd0,
        OP_RCV = 3'd1,
        OP_SET = 3'd2,
        OP_ADD = 3'd3,
        OP_MUL = 3'd4,
        OP_MOD = 3'd5,
        OP_JGZ = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        WR_Y,
        WR_ADD,
        WR_MUL,
        WR_MOD
    } wr_src_t;

    typedef enum logic [1:0] {
        MS_LL,
        MS_HL,
        MS_LH
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_MUL_END,
        ST_DIV,
        ST_DIV_END,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     exec;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mul_acc;
        logic     div_step;
        logic     wr_en;
        wr_src_t  wr_src;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       y_zero;
    } status_t;

endpackage

// ----- src/duet_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duet_ctrl
// Sequencer: steps each request through fetch, execute, the multi-cycle
// multiply or modulo, and the hand-off to the output register.
// ----------------------------------------------------------------------------
module duet_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  duet_pkg::status_t status,
    output duet_pkg::cmd_t    cmd
);
    import duet_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MS_LL;
        cmd.wr_src     = WR_Y;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                cnt_next   = '0;
                state_next = ST_FIN;
                case (status.func)
                    OP_SET:
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = WR_Y;
                    end
                    OP_ADD:
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = WR_ADD;
                    end
                    OP_MUL:
                    begin
                        state_next = ST_MUL;
                    end
                    OP_MOD:
                    begin
                        if (!status.y_zero)
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MUL:
            begin
                // One partial product per cycle; the previous one is summed in.
                cmd.mul_en  = 1'b1;
                cmd.mul_acc = (cnt_reg != '0);
                case (cnt_reg[1:0])
                    2'd0:    cmd.mul_sel = MS_LL;
                    2'd1:    cmd.mul_sel = MS_HL;
                    default: cmd.mul_sel = MS_LH;
                endcase
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_MUL_END;
                end
            end
            ST_MUL_END:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_MUL;
                state_next = ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_MOD;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- src/duet_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duet_datapath
// Register file, operand selection, shared 32x32 multiplier, restoring
// remainder unit and the result registers.
// ----------------------------------------------------------------------------
module duet_datapath #(
    parameter int NUM_REGS = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  duet_pkg::cmd_t       cmd,
    output duet_pkg::status_t    status,
    input  logic [2:0]           func,
    input  logic                 x_is_imm,
    input  logic signed [31:0]   x_value,
    input  logic                 y_is_imm,
    input  logic signed [31:0]   y_value,
    output logic signed [63:0]   pc_step,
    output logic                 recovered,
    output logic signed [63:0]   recovered_value,
    output logic                 mod_by_zero
);
    import duet_pkg::*;

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Captured request.
    logic [2:0]         func_reg;
    logic               x_is_imm_reg, y_is_imm_reg;
    logic [FIELD_W-1:0] x_value_reg, y_value_reg;

    // Register file: memory plus a valid bit per entry cleared at reset.
    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [DATA_W-1:0]   rd_x_reg, rd_y_reg;
    logic                x_ok_reg, y_ok_reg;

    logic [DATA_W-1:0] last_sound_reg;

    // Multiplier.
    logic [DATA_W-1:0]  ma_reg, mb_reg, prod_reg, acc_reg;
    logic               prod_sh_reg;
    logic [FIELD_W-1:0] mul_a, mul_b;
    logic [DATA_W-1:0]  contrib, mul_sum;

    // Remainder unit.
    logic [DATA_W-1:0] div_q_reg, div_b_reg, div_r_reg;
    logic              div_neg_reg;
    logic [DATA_W:0]   div_rs, div_diff;
    logic [DATA_W-1:0] rem_val;

    // Staged and delivered result.
    logic [DATA_W-1:0] res_step_reg, res_recv_reg;
    logic              res_rec_reg, res_mz_reg;
    logic [DATA_W-1:0] pc_step_reg, recv_reg;
    logic              rec_reg, mz_reg;

    logic [IDX_W-1:0]  x_idx, y_idx;
    logic              x_in_range, y_in_range;
    logic [DATA_W-1:0] dst, yreg, xv, yv, wr_data;
    logic              xv_pos;

    assign x_idx      = x_value_reg[IDX_W-1:0];
    assign y_idx      = y_value_reg[IDX_W-1:0];
    assign x_in_range = (x_value_reg < FIELD_W'(NUM_REGS));
    assign y_in_range = (y_value_reg < FIELD_W'(NUM_REGS));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg     <= func;
            x_is_imm_reg <= x_is_imm;
            x_value_reg  <= x_value;
            y_is_imm_reg <= y_is_imm;
            y_value_reg  <= y_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && x_in_range)
        begin
            mem[x_idx] <= wr_data;
        end
        rd_x_reg <= mem[x_idx];
        rd_y_reg <= mem[y_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            x_ok_reg <= 1'b0;
            y_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en && x_in_range)
            begin
                vld_reg[x_idx] <= 1'b1;
            end
            x_ok_reg <= x_in_range && vld_reg[x_idx];
            y_ok_reg <= y_in_range && vld_reg[y_idx];
        end
    end

    assign dst    = x_ok_reg ? rd_x_reg : '0;
    assign yreg   = y_ok_reg ? rd_y_reg : '0;
    assign xv     = x_is_imm_reg ? {{(DATA_W-FIELD_W){x_value_reg[FIELD_W-1]}}, x_value_reg}
                                 : dst;
    assign yv     = y_is_imm_reg ? {{(DATA_W-FIELD_W){y_value_reg[FIELD_W-1]}}, y_value_reg}
                                 : yreg;
    assign xv_pos = !xv[DATA_W-1] && (xv != '0);

    assign status.func   = func_reg;
    assign status.y_zero = (yv == '0);

    // Low 64 bits of the product from three 32x32 partial products.
    assign mul_a   = (cmd.mul_sel == MS_HL) ? ma_reg[DATA_W-1:FIELD_W] : ma_reg[FIELD_W-1:0];
    assign mul_b   = (cmd.mul_sel == MS_LH) ? mb_reg[DATA_W-1:FIELD_W] : mb_reg[FIELD_W-1:0];
    assign contrib = prod_sh_reg ? {prod_reg[FIELD_W-1:0], {FIELD_W{1'b0}}} : prod_reg;
    assign mul_sum = acc_reg + contrib;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ma_reg  <= dst;
            mb_reg  <= yv;
            acc_reg <= '0;
        end
        else if (cmd.mul_acc)
        begin
            acc_reg <= mul_sum;
        end
        if (cmd.mul_en)
        begin
            prod_reg    <= mul_a * mul_b;
            prod_sh_reg <= (cmd.mul_sel != MS_LL);
        end
    end

    // Restoring remainder on magnitudes, one dividend bit per cycle.
    assign div_rs   = {div_r_reg, div_q_reg[DATA_W-1]};
    assign div_diff = div_rs - {1'b0, div_b_reg};
    assign rem_val  = div_neg_reg ? (DATA_W'(0) - div_r_reg) : div_r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            div_q_reg   <= dst[DATA_W-1] ? (DATA_W'(0) - dst) : dst;
            div_b_reg   <= yv[DATA_W-1] ? (DATA_W'(0) - yv) : yv;
            div_r_reg   <= '0;
            div_neg_reg <= dst[DATA_W-1];
        end
        else if (cmd.div_step)
        begin
            div_q_reg <= {div_q_reg[DATA_W-2:0], 1'b0};
            if (!div_diff[DATA_W])
            begin
                div_r_reg <= div_diff[DATA_W-1:0];
            end
            else
            begin
                div_r_reg <= div_rs[DATA_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (cmd.wr_src)
            WR_Y:    wr_data = yv;
            WR_ADD:  wr_data = dst + yv;
            WR_MUL:  wr_data = mul_sum;
            WR_MOD:  wr_data = rem_val;
            default: wr_data = yv;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sound_reg <= '0;
        end
        else if (cmd.exec && (func_reg == OP_SND))
        begin
            last_sound_reg <= xv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_step_reg <= ((func_reg == OP_JGZ) && xv_pos) ? yv : DATA_W'(1);
            res_rec_reg  <= (func_reg == OP_RCV) && (xv != '0);
            res_recv_reg <= ((func_reg == OP_RCV) && (xv != '0)) ? last_sound_reg : '0;
            res_mz_reg   <= (func_reg == OP_MOD) && (yv == '0);
        end
        if (cmd.out_load)
        begin
            pc_step_reg <= res_step_reg;
            rec_reg     <= res_rec_reg;
            recv_reg    <= res_recv_reg;
            mz_reg      <= res_mz_reg;
        end
    end

    assign pc_step         = pc_step_reg;
    assign recovered       = rec_reg;
    assign recovered_value = recv_reg;
    assign mod_by_zero     = mz_reg;

endmodule

// ----- src/duet_instruction_executor.sv -----
`timescale 1ns / 1ps
// From request accept to result valid: snd, rcv, set, add, jgz and unused codes pass
// through read, execute and finish; mul adds three partial products on one 32x32 multiplier
// and mod with a nonzero divisor adds a 64-step restoring remainder loop before the write.
// One request at a time: a new request is taken in the cycle after the result is
// registered; a waiting result does not block it.
// Asynchronous active-low reset clears the register file valid bits, last sound and control.
// ----------------------------------------------------------------------------
// duet_instruction_executor
// Executes one decoded duet instruction per request against a signed 64-bit
// register file and returns the program-counter step and rcv report.
// ----------------------------------------------------------------------------
module duet_instruction_executor #(
    parameter int NUM_REGS = 26
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic               x_is_imm,
    input  logic signed [31:0] x_value,
    input  logic               y_is_imm,
    input  logic signed [31:0] y_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] pc_step,
    output logic               recovered,
    output logic signed [63:0] recovered_value,
    output logic               mod_by_zero
);
    import duet_pkg::*;

    cmd_t    cmd;
    status_t status;

    duet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    duet_datapath #(
        .NUM_REGS (NUM_REGS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .func            (func),
        .x_is_imm        (x_is_imm),
        .x_value         (x_value),
        .y_is_imm        (y_is_imm),
        .y_value         (y_value),
        .pc_step         (pc_step),
        .recovered       (recovered),
        .recovered_value (recovered_value),
        .mod_by_zero     (mod_by_zero)
    );

endmodule

// ----- dv/duet_exec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duet_exec_checker
// Watches the request and result channels of the duet instruction executor.
// It keeps its own register file and last sound, and predicts the result of
// every accepted request. Each accepted result is compared, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module duet_exec_checker #(
    parameter int NUM_REGS = 26
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  func,
    input  logic        x_is_imm,
    input  logic [31:0] x_value,
    input  logic        y_is_imm,
    input  logic [31:0] y_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] pc_step,
    input  logic        recovered,
    input  logic [63:0] recovered_value,
    input  logic        mod_by_zero,
    output int          errors,
    output int          results_owed
);

    import duet_pkg::*;

    typedef struct packed {
        logic [63:0] step;
        logic        rec;
        logic [63:0] sound;
        logic        mz;
    } outcome_t;

    bit [63:0] regs [NUM_REGS];
    bit [63:0] last_sound;
    outcome_t  outcome_q [$];
    int        fails;

    // An index that does not fit the file reads as zero and drops writes.
    function automatic bit index_valid(logic [31:0] idx);
        return idx < NUM_REGS;
    endfunction

    function automatic bit [63:0] read_reg(logic [31:0] idx);
        if (!index_valid(idx))
            return 64'd0;
        return regs[idx];
    endfunction

    function automatic void write_reg(logic [31:0] idx, bit [63:0] value);
        if (index_valid(idx))
            regs[idx] = value;
    endfunction

    function automatic bit [63:0] operand_value(logic is_imm, logic [31:0] raw);
        if (is_imm)
            return {{32{raw[31]}}, raw};
        return read_reg(raw);
    endfunction

    // Remainder truncated toward zero, worked on magnitudes so that the most
    // negative dividend over minus one gives zero without overflow.
    function automatic bit [63:0] rem_trunc(bit [63:0] a, bit [63:0] b);
        bit [63:0] mag_a;
        bit [63:0] mag_b;
        bit [63:0] r;
        mag_a = a[63] ? -a : a;
        mag_b = b[63] ? -b : b;
        r = mag_a % mag_b;
        return a[63] ? -r : r;
    endfunction

    function automatic outcome_t execute_instr(logic [2:0] f, logic xi, logic [31:0] xv,
                                               logic yi, logic [31:0] yv);
        bit [63:0] xop;
        bit [63:0] yop;
        bit [63:0] dst;
        outcome_t  r;
        xop = operand_value(xi, xv);
        yop = operand_value(yi, yv);
        dst = read_reg(xv);
        r.step  = 64'd1;
        r.rec   = 1'b0;
        r.sound = 64'd0;
        r.mz    = 1'b0;
        case (f)
            OP_SND: last_sound = xop;
            OP_RCV:
            begin
                if (xop != 64'd0)
                begin
                    r.rec   = 1'b1;
                    r.sound = last_sound;
                end
            end
            OP_SET: write_reg(xv, yop);
            OP_ADD: write_reg(xv, dst + yop);
            OP_MUL: write_reg(xv, dst * yop);
            OP_MOD:
            begin
                if (yop == 64'd0)
                    r.mz = 1'b1;
                else
                    write_reg(xv, rem_trunc(dst, yop));
            end
            OP_JGZ:
            begin
                if (!xop[63] && xop != 64'd0)
                    r.step = yop;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        outcome_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                outcome_q.push_back(execute_instr(func, x_is_imm, x_value,
                                                  y_is_imm, y_value));
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting, actual pc_step %h",
                             $time, pc_step);
                    fails++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("pc_step", want.step, pc_step);
                    check_field("recovered", {63'd0, want.rec}, {63'd0, recovered});
                    check_field("recovered_value", want.sound, recovered_value);
                    check_field("mod_by_zero", {63'd0, want.mz}, {63'd0, mod_by_zero});
                end
            end
            errors       <= fails;
            results_owed <= outcome_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the duet instruction executor: a directed list of corner
// cases, then random instruction streams with idle bursts on both sides, a
// long result hold-off and a drain pause. The checker does the predicting.
// ----------------------------------------------------------------------------
module tb;

    import duet_pkg::*;

    localparam int          NUM_REGS     = 26;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          RANDOM_ITEMS = 1275;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          HOLD_AT      = 300;
    localparam int          PAUSE_AT     = 700;
    localparam logic [2:0]  FUNC_UNUSED  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic        x_is_imm;
    logic [31:0] x_value;
    logic        y_is_imm;
    logic [31:0] y_value;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] pc_step;
    logic        recovered;
    logic [63:0] recovered_value;
    logic        mod_by_zero;

    int errors;
    int results_owed;
    int cycle_count;
    bit quiet;
    bit hold_off_req;

    duet_instruction_executor #(
        .NUM_REGS (NUM_REGS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .x_is_imm        (x_is_imm),
        .x_value         (x_value),
        .y_is_imm        (y_is_imm),
        .y_value         (y_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pc_step         (pc_step),
        .recovered       (recovered),
        .recovered_value (recovered_value),
        .mod_by_zero     (mod_by_zero)
    );

    duet_exec_checker #(
        .NUM_REGS (NUM_REGS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .x_is_imm        (x_is_imm),
        .x_value         (x_value),
        .y_is_imm        (y_is_imm),
        .y_value         (y_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pc_step         (pc_step),
        .recovered       (recovered),
        .recovered_value (recovered_value),
        .mod_by_zero     (mod_by_zero),
        .errors          (errors),
        .results_owed    (results_owed)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side: random short stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        int unsigned burst;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (burst - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic issue(input logic [2:0] f, input logic xi, input logic [31:0] xv,
                         input logic yi, input logic [31:0] yv);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        x_is_imm <= xi;
        x_value  <= xv;
        y_is_imm <= yi;
        y_value  <= yv;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] pick_index();
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1:       return $urandom_range(NUM_REGS, 31);
            default: return $urandom_range(0, NUM_REGS - 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 16) - 8;
            1:       return 32'h7FFFFFFF;
            2:       return 32'h80000000;
            3:       return $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_func();
        case ($urandom_range(0, 15))
            0, 1:    return OP_SND;
            2, 3:    return OP_RCV;
            4, 5:    return OP_SET;
            6, 7:    return OP_ADD;
            8, 9:    return OP_MUL;
            10, 11:  return OP_MOD;
            12, 13:  return OP_JGZ;
            14:      return FUNC_UNUSED;
            default: return OP_SET;
        endcase
    endfunction

    initial
    begin : stimulus
        logic [2:0]  f;
        logic        xi;
        logic        yi;
        logic [31:0] xv;
        logic [31:0] yv;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= OP_SND;
        x_is_imm     <= 1'b0;
        x_value      <= 32'd0;
        y_is_imm     <= 1'b0;
        y_value      <= 32'd0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Build the most negative value in r0; the immediate flag on a
        // destination must be ignored.
        issue(OP_SET, 1'b1, 32'd0, 1'b1, 32'h80000000);
        issue(OP_MUL, 1'b0, 32'd0, 1'b0, 32'd0);
        issue(OP_MUL, 1'b0, 32'd0, 1'b1, -32'sd2);
        issue(OP_SET, 1'b0, 32'd1, 1'b0, 32'd0);
        issue(OP_MOD, 1'b0, 32'd1, 1'b1, 32'hFFFFFFFF);
        issue(OP_MOD, 1'b0, 32'd0, 1'b1, 32'd0);
        issue(OP_MOD, 1'b0, 32'd0, 1'b0, 32'd25);
        issue(OP_SET, 1'b0, 32'd2, 1'b1, -32'sd7);
        issue(OP_MOD, 1'b0, 32'd2, 1'b1, 32'd3);
        issue(OP_SET, 1'b0, 32'd3, 1'b1, 32'h7FFFFFFF);
        issue(OP_MOD, 1'b0, 32'd3, 1'b1, -32'sd5);
        issue(OP_ADD, 1'b0, 32'd3, 1'b1, 32'h7FFFFFFF);
        // Writes and reads outside the register file.
        issue(OP_SET, 1'b0, 32'd26, 1'b1, 32'd5);
        issue(OP_SET, 1'b0, 32'hFFFFFFFF, 1'b1, 32'd5);
        issue(OP_ADD, 1'b0, 32'd4, 1'b0, 32'd30);
        issue(OP_SND, 1'b0, 32'd0, 1'b0, 32'd0);
        issue(OP_RCV, 1'b1, 32'd0, 1'b0, 32'd0);
        issue(OP_RCV, 1'b1, 32'hFFFFFFFF, 1'b0, 32'd0);
        issue(OP_SND, 1'b1, 32'h7FFFFFFF, 1'b1, 32'd0);
        issue(OP_RCV, 1'b0, 32'd2, 1'b1, 32'd0);
        issue(OP_JGZ, 1'b1, 32'd1, 1'b1, 32'h80000000);
        issue(OP_JGZ, 1'b1, 32'd0, 1'b1, 32'd5);
        issue(OP_JGZ, 1'b0, 32'd3, 1'b0, 32'd0);
        issue(OP_JGZ, 1'b1, 32'hFFFFFFFF, 1'b1, 32'd7);
        issue(FUNC_UNUSED, 1'b1, $urandom, 1'b0, 32'd1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_AT)
                hold_off_req = 1'b1;
            if (i == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (results_owed != 0);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            f  = pick_func();
            xi = $urandom_range(0, 1);
            yi = $urandom_range(0, 1);
            yv = yi ? pick_imm() : pick_index();
            if (f == OP_SND || f == OP_RCV || f == OP_JGZ || f == FUNC_UNUSED)
                xv = xi ? pick_imm() : pick_index();
            else
                xv = pick_index();
            issue(f, xi, xv, yi, yv);
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && results_owed == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
